/* rtl/core/nsqrt_pkg.sv */
`default_nettype none
package nsqrt_pkg;

   localparam int MAX_ITERATIONS = 8;
   localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
   // quotient bits: 53 significand bits and one guard bit
   localparam int DIV_STEPS = 54;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   // working exponent of values near one, two's complement
   localparam int EX_W = 6;
   localparam int E_W = 12;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CLASSIFY,
      CMD_NORM_SHIFT,
      CMD_ODD_FIX,
      CMD_ADD,
      CMD_ROUND,
      CMD_DIV_START,
      CMD_DIV_STEP,
      CMD_DIV_ROUND,
      CMD_COMPOSE,
      CMD_OUT_LOAD
   } op_type;

   typedef struct packed {
      op_type op;
      logic   init;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic zero;
      logic lead;
      logic y_eq_z;
   } status_type;

endpackage
`default_nettype wire

/* rtl/core/nsqrt_dp.sv */
`default_nettype none
module nsqrt_dp (
   input  wire                   clock,
   input  wire  [63:0]           req_operand_bits,
   input  wire nsqrt_pkg::cmd_type cmd,
   output nsqrt_pkg::status_type status,
   output logic [63:0]           rsp_root_bits,
   output logic                  rsp_special_input
);
   import nsqrt_pkg::*;

   logic [63:0]            op_ff;
   logic signed [E_W-1:0]  e_ff;
   logic [52:0]            msig_ff;
   logic signed [EX_W-1:0] mex_ff;
   logic [52:0]            ysig_ff, zsig_ff, qsig_ff;
   logic signed [EX_W-1:0] yex_ff, zex_ff, qex_ff;
   logic [54:0]            rem_ff;
   logic [53:0]            quo_ff;
   logic [56:0]            sum_ff;
   logic signed [EX_W-1:0] sumex_ff;
   logic [63:0]            result_ff;
   logic                   special_ff;
   logic [63:0]            root_ff;
   logic                   rspec_ff;

   logic                   sgn;
   logic [10:0]            ef;
   logic [51:0]            frac;
   logic                   is_special, is_zero;
   logic [10:0]            efx;

   logic [52:0]            a_sig, b_sig, hi_sig, lo_sig;
   logic signed [EX_W-1:0] a_ex, b_ex, hi_ex, lo_ex;
   logic [EX_W-1:0]        align_sh;
   logic [55:0]            lo_ext, lo_sh, lo_mask;
   logic                   lo_sticky;
   logic [56:0]            sum_in;

   logic [55:0]            nv;
   logic signed [EX_W-1:0] nex;
   logic [53:0]            ar;
   logic [52:0]            ar_sig;
   logic signed [EX_W-1:0] ar_ex;

   logic [53:0]            dr;
   logic [52:0]            dr_sig;
   logic signed [EX_W-1:0] dr_ex;
   logic [54:0]            ysig_ext;

   logic signed [E_W-1:0]  half_e;
   logic [E_W-1:0]         exp_sum;

   function automatic logic [53:0] rne(input logic [52:0] sig, input logic g,
                                       input logic s);
      logic up;
      up = g & (s | sig[0]);
      return {1'b0, sig} + {53'd0, up};
   endfunction

   // operand classes
   always_comb begin
      sgn        = op_ff[63];
      ef         = op_ff[62:52];
      frac       = op_ff[51:0];
      is_special = (ef == 11'h7FF) && ((frac != 52'd0) || !sgn);
      is_zero    = (ef == 11'h7FF) || sgn || ((ef == 11'd0) && (frac == 52'd0));
      efx        = (ef == 11'd0) ? 11'd1 : ef;
   end

   // adder alignment
   always_comb begin
      if (cmd.init) begin
         a_sig = {1'b1, 52'd0};
         a_ex  = '0;
         b_sig = msig_ff;
         b_ex  = mex_ff;
      end else begin
         a_sig = ysig_ff;
         a_ex  = yex_ff;
         b_sig = qsig_ff;
         b_ex  = qex_ff;
      end
      if (b_ex > a_ex) begin
         hi_sig = b_sig; hi_ex = b_ex; lo_sig = a_sig; lo_ex = a_ex;
      end else begin
         hi_sig = a_sig; hi_ex = a_ex; lo_sig = b_sig; lo_ex = b_ex;
      end
      align_sh  = EX_W'(hi_ex - lo_ex);
      lo_ext    = {lo_sig, 3'b000};
      lo_sh     = lo_ext >> align_sh;
      lo_mask   = ~({56{1'b1}} << align_sh);
      lo_sticky = |(lo_ext & lo_mask);
      sum_in    = {1'b0, hi_sig, 3'b000} + {1'b0, lo_sh[55:1], lo_sh[0] | lo_sticky};
   end

   // adder normalize and round
   always_comb begin
      if (sum_ff[56]) begin
         nv  = {sum_ff[56:2], sum_ff[1] | sum_ff[0]};
         nex = sumex_ff + EX_W'(1);
      end else begin
         nv  = sum_ff[55:0];
         nex = sumex_ff;
      end
      ar = rne(nv[55:3], nv[2], nv[1] | nv[0]);
      if (ar[53]) begin
         ar_sig = {1'b1, 52'd0};
         ar_ex  = nex + EX_W'(1);
      end else begin
         ar_sig = ar[52:0];
         ar_ex  = nex;
      end
   end

   // quotient round
   always_comb begin
      ysig_ext = {2'b00, ysig_ff};
      dr = rne(quo_ff[53:1], quo_ff[0], rem_ff != 55'd0);
      if (dr[53]) begin
         dr_sig = {1'b1, 52'd0};
         dr_ex  = qex_ff + EX_W'(1);
      end else begin
         dr_sig = dr[52:0];
         dr_ex  = qex_ff;
      end
   end

   always_comb begin
      half_e  = e_ff >>> 1;
      exp_sum = half_e + {{(E_W - EX_W){yex_ff[EX_W-1]}}, yex_ff} + E_W'(1023);
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_LOAD: begin
            op_ff <= req_operand_bits;
         end
         CMD_CLASSIFY: begin
            result_ff  <= is_special ? op_ff : 64'd0;
            special_ff <= is_special;
            msig_ff    <= {ef != 11'd0, frac};
            mex_ff     <= -EX_W'(1);
            e_ff       <= $signed({1'b0, efx} - E_W'(1022));
         end
         CMD_NORM_SHIFT: begin
            msig_ff <= {msig_ff[51:0], 1'b0};
            e_ff    <= e_ff - E_W'(1);
         end
         CMD_ODD_FIX: begin
            if (e_ff[0]) begin
               e_ff   <= e_ff - E_W'(1);
               mex_ff <= '0;
            end
         end
         CMD_ADD: begin
            sum_ff   <= sum_in;
            sumex_ff <= hi_ex;
         end
         CMD_ROUND: begin
            // result halved exactly
            ysig_ff <= ar_sig;
            yex_ff  <= ar_ex - EX_W'(1);
            if (cmd.init) begin
               zsig_ff <= '0;
               zex_ff  <= '0;
            end else begin
               zsig_ff <= ysig_ff;
               zex_ff  <= yex_ff;
            end
         end
         CMD_DIV_START: begin
            quo_ff <= '0;
            if (msig_ff < ysig_ff) begin
               rem_ff <= {1'b0, msig_ff, 1'b0};
               qex_ff <= mex_ff - yex_ff - EX_W'(1);
            end else begin
               rem_ff <= {2'b00, msig_ff};
               qex_ff <= mex_ff - yex_ff;
            end
         end
         CMD_DIV_STEP: begin
            if (rem_ff >= ysig_ext) begin
               quo_ff <= {quo_ff[52:0], 1'b1};
               rem_ff <= {rem_ff[53:0] - ysig_ext[53:0], 1'b0};
            end else begin
               quo_ff <= {quo_ff[52:0], 1'b0};
               rem_ff <= {rem_ff[53:0], 1'b0};
            end
         end
         CMD_DIV_ROUND: begin
            qsig_ff <= dr_sig;
            qex_ff  <= dr_ex;
         end
         CMD_COMPOSE: begin
            result_ff  <= {1'b0, exp_sum[10:0], ysig_ff[51:0]};
            special_ff <= 1'b0;
         end
         CMD_OUT_LOAD: begin
            root_ff  <= result_ff;
            rspec_ff <= special_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.special = is_special;
   assign status.zero    = is_zero;
   assign status.lead    = msig_ff[52];
   assign status.y_eq_z  = (ysig_ff == zsig_ff) && (yex_ff == zex_ff);

   assign rsp_root_bits     = root_ff;
   assign rsp_special_input = rspec_ff;

endmodule
`default_nettype wire

/* rtl/core/nsqrt_ctrl.sv */
`default_nettype none
module nsqrt_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   input  wire nsqrt_pkg::status_type status,
   output nsqrt_pkg::cmd_type    cmd
);
   import nsqrt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLASSIFY, ST_NORM, ST_ADD, ST_ROUND, ST_CHECK,
      ST_DIV_START, ST_DIV, ST_DIV_ROUND, ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic                   init_ff, init_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic [DIV_CNT_W-1:0]   dcnt_ff, dcnt_in;
   logic                   valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      iter_in  = iter_ff;
      dcnt_in  = dcnt_ff;
      valid_in = valid_ff && rsp_stall;
      cmd.op   = CMD_NONE;
      cmd.init = init_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = CMD_LOAD;
               init_in  = 1'b1;
               iter_in  = '0;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.op   = CMD_CLASSIFY;
            state_in = (status.special || status.zero) ? ST_FINISH : ST_NORM;
         end
         ST_NORM: begin
            // subnormal mantissa moves up one bit a cycle
            if (status.lead) begin
               cmd.op   = CMD_ODD_FIX;
               state_in = ST_ADD;
            end else begin
               cmd.op = CMD_NORM_SHIFT;
            end
         end
         ST_ADD: begin
            cmd.op   = CMD_ADD;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.op  = CMD_ROUND;
            init_in = 1'b0;
            if (init_ff) begin
               state_in = ST_DIV_START;
            end else begin
               iter_in  = iter_ff + ITER_W'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((iter_ff == ITER_W'(MAX_ITERATIONS)) || status.y_eq_z) begin
               cmd.op   = CMD_COMPOSE;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.op   = CMD_DIV_START;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op  = CMD_DIV_STEP;
            dcnt_in = dcnt_ff + DIV_CNT_W'(1);
            if (dcnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DIV_ROUND;
            end
         end
         ST_DIV_ROUND: begin
            cmd.op   = CMD_DIV_ROUND;
            state_in = ST_ADD;
         end
         ST_FINISH: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.op   = CMD_OUT_LOAD;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         init_ff  <= 1'b0;
         iter_ff  <= '0;
         dcnt_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         iter_ff  <= iter_in;
         dcnt_ff  <= dcnt_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

`ifndef ASSERT_OFF
   a_accept_classify: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CLASSIFY))
      else $error("accepted item not classified");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_W'(MAX_ITERATIONS))
      else $error("iteration count past limit");
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !(valid_ff && rsp_stall)) |=> (valid_ff && state_ff == ST_IDLE))
      else $error("finished item not presented");
   a_div_only_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_ROUND) |-> ($past(state_ff) == ST_DIV))
      else $error("quotient rounded without divide");
`endif

endmodule
`default_nettype wire

/* rtl/core/newton_square_root_double_unit.sv */
`default_nettype none
// channel  ports                                       direction
// req      req_valid, req_stall, req_operand_bits      in (stall out)
// rsp      rsp_valid, rsp_stall, rsp_root_bits,        out (stall in)
//          rsp_special_input
// one item at a time; special, zero and negative operands skip the newton steps
// finite positive operands run up to 8 newton steps, each one a divide in
// the radix-2 divider that forms a 54-bit quotient
// subnormal operands first shift the significand up until its leading bit is set
// a finished result sits in the output register while the next item starts
// reset is synchronous; no item is taken while one is in flight
module newton_square_root_double_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_operand_bits,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_root_bits,
   output logic        rsp_special_input
);
   import nsqrt_pkg::*;

   cmd_type    cmd;
   status_type status;

   nsqrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nsqrt_dp u_dp (
      .clock             (clock),
      .req_operand_bits  (req_operand_bits),
      .cmd               (cmd),
      .status            (status),
      .rsp_root_bits     (rsp_root_bits),
      .rsp_special_input (rsp_special_input)
   );

endmodule
`default_nettype wire
